// ===== src/alle_pkg.sv =====
`default_nettype none
package alle_pkg;

    localparam int LINK_W = 7;
    localparam int DATA_W = 32;
    localparam logic [LINK_W-1:0] NULL_LINK = 7'd127;

    typedef enum logic [1:0] {
        KIND_ADD_HEAD = 2'd0,
        KIND_ADD_TAIL = 2'd1,
        KIND_DELETE   = 2'd2,
        KIND_READ_OUT = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_EMPTY     = 2'd2,
        STATUS_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_START = 2'd1,
        S_WALK  = 2'd2
    } state_t;

    typedef struct packed {
        logic              rd_en;
        logic [LINK_W-1:0] rd_addr;
        logic              wr_value_en;
        logic              wr_link_en;
        logic [LINK_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_value;
        logic [LINK_W-1:0] wr_link;
    } mem_req_t;

    typedef struct packed {
        logic              valid;
        status_t           status;
        logic [DATA_W-1:0] data;
        logic              last;
    } emit_t;

endpackage
`default_nettype wire

// ===== src/alle_store.sv =====
`default_nettype none
module alle_store #(
    parameter int CAPACITY = 64
) (
    input  wire logic                         aclk,
    input  wire alle_pkg::mem_req_t           req,
    output logic [alle_pkg::DATA_W-1:0]       rd_value,
    output logic [alle_pkg::LINK_W-1:0]       rd_link
);
    import alle_pkg::*;

    localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [DATA_W-1:0] value_mem [CAPACITY];
    logic [LINK_W-1:0] link_mem  [CAPACITY];

    always_ff @(posedge aclk) begin
        if (req.wr_value_en) begin
            value_mem[req.wr_addr[SLOT_W-1:0]] <= req.wr_value;
        end
        if (req.wr_link_en) begin
            link_mem[req.wr_addr[SLOT_W-1:0]] <= req.wr_link;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_value <= value_mem[req.rd_addr[SLOT_W-1:0]];
            rd_link  <= link_mem[req.rd_addr[SLOT_W-1:0]];
        end
    end

endmodule
`default_nettype wire

// ===== src/alle_ctrl.sv =====
`default_nettype none
module alle_ctrl #(
    parameter int CAPACITY = 64
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         req_valid,
    output logic                              req_ready,
    input  wire alle_pkg::kind_t              req_kind,
    input  wire logic [alle_pkg::DATA_W-1:0]  req_value,
    input  wire logic                         out_free,
    output alle_pkg::emit_t                   emit,
    output alle_pkg::mem_req_t                mem,
    input  wire logic [alle_pkg::DATA_W-1:0]  rd_value,
    input  wire logic [alle_pkg::LINK_W-1:0]  rd_link
);
    import alle_pkg::*;

    state_t            state_reg, state_next;
    kind_t             op_reg, op_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [LINK_W-1:0] head_reg, head_next;
    logic [LINK_W-1:0] fill_reg, fill_next;
    logic [LINK_W-1:0] node_reg, node_next;
    logic [LINK_W-1:0] prev_reg, prev_next;
    logic              first_reg, first_next;

    logic is_add, full, head_null, link_null, hit;

    assign is_add    = (op_reg == KIND_ADD_HEAD) || (op_reg == KIND_ADD_TAIL);
    assign full      = fill_reg >= LINK_W'(CAPACITY);
    assign head_null = head_reg == NULL_LINK;
    assign link_null = rd_link == NULL_LINK;
    assign hit       = rd_value == val_reg;
    assign req_ready = state_reg == S_IDLE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            head_reg  <= NULL_LINK;
            fill_reg  <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        val_reg   <= val_next;
        node_reg  <= node_next;
        prev_reg  <= prev_next;
        first_reg <= first_next;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    state_next = S_START;
                end
            end
            S_START: begin
                if (is_add && full) begin
                    if (out_free) state_next = S_IDLE;
                end else if (op_reg == KIND_ADD_HEAD) begin
                    if (out_free) state_next = S_IDLE;
                end else if (head_null) begin
                    if (out_free) state_next = S_IDLE;
                end else begin
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                case (op_reg)
                    KIND_ADD_TAIL: begin
                        if (link_null && out_free) state_next = S_IDLE;
                    end
                    KIND_DELETE: begin
                        if ((hit || link_null) && out_free) state_next = S_IDLE;
                    end
                    default: begin
                        if (link_null && out_free) state_next = S_IDLE;
                    end
                endcase
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        op_next    = op_reg;
        val_next   = val_reg;
        head_next  = head_reg;
        fill_next  = fill_reg;
        node_next  = node_reg;
        prev_next  = prev_reg;
        first_next = first_reg;
        emit       = '{valid: 1'b0, status: STATUS_OK, data: '0, last: 1'b1};
        mem        = '0;
        mem.wr_addr  = fill_reg;
        mem.wr_value = val_reg;
        mem.wr_link  = NULL_LINK;
        case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    op_next  = req_kind;
                    val_next = req_value;
                end
            end
            S_START: begin
                if (is_add && full) begin
                    emit.valid  = out_free;
                    emit.status = STATUS_FULL;
                end else if (op_reg == KIND_ADD_HEAD) begin
                    if (out_free) begin
                        mem.wr_value_en = 1'b1;
                        mem.wr_link_en  = 1'b1;
                        mem.wr_link     = head_reg;
                        head_next       = fill_reg;
                        fill_next       = fill_reg + 1'b1;
                        emit.valid      = 1'b1;
                    end
                end else if (head_null) begin
                    if (op_reg == KIND_ADD_TAIL) begin
                        if (out_free) begin
                            mem.wr_value_en = 1'b1;
                            mem.wr_link_en  = 1'b1;
                            head_next       = fill_reg;
                            fill_next       = fill_reg + 1'b1;
                            emit.valid      = 1'b1;
                        end
                    end else begin
                        emit.valid  = out_free;
                        emit.status = STATUS_EMPTY;
                    end
                end else begin
                    if (op_reg == KIND_ADD_TAIL) begin
                        mem.wr_value_en = 1'b1;
                        mem.wr_link_en  = 1'b1;
                    end
                    mem.rd_en   = 1'b1;
                    mem.rd_addr = head_reg;
                    node_next   = head_reg;
                    first_next  = 1'b1;
                end
            end
            S_WALK: begin
                case (op_reg)
                    KIND_ADD_TAIL: begin
                        if (link_null) begin
                            if (out_free) begin
                                mem.wr_link_en = 1'b1;
                                mem.wr_addr    = node_reg;
                                mem.wr_link    = fill_reg;
                                fill_next      = fill_reg + 1'b1;
                                emit.valid     = 1'b1;
                            end
                        end else begin
                            mem.rd_en   = 1'b1;
                            mem.rd_addr = rd_link;
                            prev_next   = node_reg;
                            node_next   = rd_link;
                            first_next  = 1'b0;
                        end
                    end
                    KIND_DELETE: begin
                        if (hit) begin
                            if (out_free) begin
                                if (first_reg) begin
                                    head_next = rd_link;
                                end else begin
                                    mem.wr_link_en = 1'b1;
                                    mem.wr_addr    = prev_reg;
                                    mem.wr_link    = rd_link;
                                end
                                emit.valid = 1'b1;
                            end
                        end else if (link_null) begin
                            emit.valid  = out_free;
                            emit.status = STATUS_NOT_FOUND;
                        end else begin
                            mem.rd_en   = 1'b1;
                            mem.rd_addr = rd_link;
                            prev_next   = node_reg;
                            node_next   = rd_link;
                            first_next  = 1'b0;
                        end
                    end
                    default: begin
                        if (out_free) begin
                            emit.valid = 1'b1;
                            emit.data  = rd_value;
                            emit.last  = link_null;
                            if (!link_null) begin
                                mem.rd_en   = 1'b1;
                                mem.rd_addr = rd_link;
                                prev_next   = node_reg;
                                node_next   = rd_link;
                                first_next  = 1'b0;
                            end
                        end
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== src/array_linked_list_engine.sv =====
`default_nettype none
// Channel  Dir  tdata              tuser          tlast
// s_axis   in   [31:0] value       [1:0] kind     -
// m_axis   out  [31:0] data        [1:0] status   last of request
//
// A request is taken only when the engine is idle. Add at head, a full or
// empty case finish in the start state; tail add, delete and read out walk
// the list, one store read per node.
// Reset (aresetn low, synchronous) empties the list; the stores need no clear.
// A stalled m_axis holds a read-out walk in place until the result register frees; tail add and delete wait to emit.
module array_linked_list_engine #(
    parameter int CAPACITY = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] value
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] data
    output logic [1:0]       m_axis_tuser,   // [1:0] status
    output logic             m_axis_tlast
);
    import alle_pkg::*;

    mem_req_t          mem;
    emit_t             emit;
    logic [DATA_W-1:0] rd_value;
    logic [LINK_W-1:0] rd_link;
    logic              out_free;

    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_data_reg, m_data_next;
    status_t           m_status_reg, m_status_next;
    logic              m_last_reg, m_last_next;

    assign out_free = !m_valid_reg || m_axis_tready;

    alle_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .req_kind  (kind_t'(s_axis_tuser)),
        .req_value (s_axis_tdata),
        .out_free  (out_free),
        .emit      (emit),
        .mem       (mem),
        .rd_value  (rd_value),
        .rd_link   (rd_link)
    );

    alle_store #(
        .CAPACITY(CAPACITY)
    ) u_store (
        .aclk     (aclk),
        .req      (mem),
        .rd_value (rd_value),
        .rd_link  (rd_link)
    );

    always_comb begin
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_data_next   = m_data_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;
        if (emit.valid) begin
            m_valid_next  = 1'b1;
            m_data_next   = emit.data;
            m_status_next = emit.status;
            m_last_next   = emit.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg   <= m_data_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule
`default_nettype wire

// ===== test/array_linked_list_engine_tb.sv =====
`default_nettype none
module array_linked_list_engine_tb;
    import alle_pkg::*;

    localparam int CAPACITY       = 64;
    localparam int LINK_SPAN      = 1 << LINK_W;
    localparam int TOTAL_REQUESTS = 470;
    localparam int SCRIPT_LEN     = 26;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4 * CAPACITY;

    typedef struct packed {
        status_t           status;
        logic [DATA_W-1:0] data;
        logic              last;
    } list_result_t;

    typedef struct packed {
        kind_t             kind;
        logic [DATA_W-1:0] value;
        logic              pinned;   // expected status typed in below
        status_t           status;
    } script_row_t;

    logic              aclk;
    logic              aresetn;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata;
    logic [1:0]        s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [31:0]       m_axis_tdata;
    logic [1:0]        m_axis_tuser;
    logic              m_axis_tlast;

    // list shadow, indexed by the full link code
    logic [DATA_W-1:0] node_value [0:LINK_SPAN-1];
    logic [LINK_W-1:0] node_next  [0:LINK_SPAN-1];
    logic [LINK_W-1:0] head_slot;
    int                used_slots;
    int                list_len;

    list_result_t      step_results[$];
    list_result_t      awaited_results[$];

    int                error_count   = 0;
    int                results_seen  = 0;
    int                idle_cycles   = 0;
    int                full_rejects  = 0;
    int                longest_walk  = 0;
    int                kind_count [0:3];
    int                calm_left     = 0;
    int                ready_hold    = 0;
    int                ready_roll;
    int                i;

    script_row_t script_rows [0:SCRIPT_LEN-1] = '{
        '{KIND_READ_OUT, 32'h0000_0000, 1'b1, STATUS_EMPTY},
        '{KIND_DELETE,   32'h0000_0005, 1'b1, STATUS_EMPTY},
        '{KIND_ADD_TAIL, 32'h8000_0000, 1'b1, STATUS_OK},
        '{KIND_ADD_HEAD, 32'h7FFF_FFFF, 1'b1, STATUS_OK},
        '{KIND_ADD_TAIL, 32'hFFFF_FFFF, 1'b1, STATUS_OK},
        '{KIND_ADD_HEAD, 32'h0000_0000, 1'b1, STATUS_OK},
        '{KIND_ADD_TAIL, 32'h0000_0005, 1'b1, STATUS_OK},
        '{KIND_ADD_TAIL, 32'h0000_0005, 1'b1, STATUS_OK},
        '{KIND_READ_OUT, 32'hFFFF_FFFF, 1'b0, STATUS_OK},
        '{KIND_DELETE,   32'h1234_5678, 1'b1, STATUS_NOT_FOUND},
        '{KIND_DELETE,   32'h0000_0000, 1'b1, STATUS_OK},
        '{KIND_DELETE,   32'h0000_0005, 1'b0, STATUS_OK},
        '{KIND_READ_OUT, 32'h0000_0000, 1'b0, STATUS_OK},
        '{KIND_DELETE,   32'h0000_0005, 1'b0, STATUS_OK},
        '{KIND_DELETE,   32'hFFFF_FFFE, 1'b1, STATUS_NOT_FOUND},
        '{KIND_READ_OUT, 32'h5555_5555, 1'b0, STATUS_OK},
        '{KIND_ADD_HEAD, 32'hAAAA_AAAA, 1'b1, STATUS_OK},
        '{KIND_ADD_TAIL, 32'h5555_5555, 1'b1, STATUS_OK},
        '{KIND_DELETE,   32'h8000_0000, 1'b0, STATUS_OK},
        '{KIND_DELETE,   32'h7FFF_FFFF, 1'b0, STATUS_OK},
        '{KIND_DELETE,   32'hFFFF_FFFF, 1'b0, STATUS_OK},
        '{KIND_READ_OUT, 32'hAAAA_AAAA, 1'b0, STATUS_OK},
        '{KIND_DELETE,   32'hAAAA_AAAA, 1'b0, STATUS_OK},
        '{KIND_DELETE,   32'h5555_5555, 1'b0, STATUS_OK},
        '{KIND_READ_OUT, 32'h0000_0000, 1'b1, STATUS_EMPTY},
        '{KIND_DELETE,   32'h5555_5555, 1'b1, STATUS_EMPTY}
    };

    array_linked_list_engine #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic void push_result(status_t status, logic [DATA_W-1:0] data, logic last);
        step_results.push_back('{status: status, data: data, last: last});
    endfunction

    // Applies one request to the shadow list and leaves its results in step_results.
    function automatic void predict_list_request(kind_t kind, logic [DATA_W-1:0] value);
        logic [LINK_W-1:0] cur;
        logic [LINK_W-1:0] nxt;
        logic [LINK_W-1:0] slot;
        int                steps;
        bit                done;
        step_results.delete();
        kind_count[kind]++;
        case (kind)
            KIND_ADD_HEAD, KIND_ADD_TAIL: begin
                if (used_slots >= CAPACITY) begin
                    full_rejects++;
                    push_result(STATUS_FULL, '0, 1'b1);
                end else begin
                    slot = used_slots[LINK_W-1:0];
                    node_value[slot] = value;
                    if (kind == KIND_ADD_HEAD) begin
                        node_next[slot] = head_slot;
                        head_slot = slot;
                    end else begin
                        node_next[slot] = NULL_LINK;
                        if (head_slot == NULL_LINK) begin
                            head_slot = slot;
                        end else begin
                            cur = head_slot;
                            steps = 0;
                            while (steps < CAPACITY && node_next[cur] != NULL_LINK) begin
                                cur = node_next[cur];
                                steps++;
                            end
                            node_next[cur] = slot;
                        end
                    end
                    used_slots++;
                    list_len++;
                    push_result(STATUS_OK, '0, 1'b1);
                end
            end
            KIND_DELETE: begin
                if (head_slot == NULL_LINK) begin
                    push_result(STATUS_EMPTY, '0, 1'b1);
                end else if (node_value[head_slot] == value) begin
                    head_slot = node_next[head_slot];
                    list_len--;
                    push_result(STATUS_OK, '0, 1'b1);
                end else begin
                    cur = head_slot;
                    steps = 0;
                    done = 1'b0;
                    while (steps < CAPACITY && !done) begin
                        nxt = node_next[cur];
                        if (nxt == NULL_LINK || node_value[nxt] == value) begin
                            done = 1'b1;
                        end else begin
                            cur = nxt;
                        end
                        steps++;
                    end
                    nxt = node_next[cur];
                    if (nxt == NULL_LINK || node_value[nxt] != value) begin
                        push_result(STATUS_NOT_FOUND, '0, 1'b1);
                    end else begin
                        node_next[cur] = node_next[nxt];
                        list_len--;
                        push_result(STATUS_OK, '0, 1'b1);
                    end
                end
            end
            default: begin
                if (head_slot == NULL_LINK) begin
                    push_result(STATUS_EMPTY, '0, 1'b1);
                end else begin
                    cur = head_slot;
                    steps = 0;
                    while (cur != NULL_LINK && steps < CAPACITY) begin
                        nxt = node_next[cur];
                        push_result(STATUS_OK, node_value[cur],
                                    (nxt == NULL_LINK) || (steps + 1 >= CAPACITY));
                        steps++;
                        cur = nxt;
                    end
                    if (steps > longest_walk) longest_walk = steps;
                end
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int roll;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            calm_left = $urandom_range(10, 30);
            return 0;
        end else if (roll < 55) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return $urandom_range(0, 15);
        if (roll < 50) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'hFFFF_FFFF;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom;
    endfunction

    task automatic send_request(kind_t kind, logic [DATA_W-1:0] value, logic pinned,
                                status_t pinned_status);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= kind;
        do @(posedge aclk); while (!s_axis_tready);
        predict_list_request(kind, value);
        if (pinned) begin
            awaited_results.push_back('{status: pinned_status, data: '0, last: 1'b1});
        end else begin
            foreach (step_results[k]) awaited_results.push_back(step_results[k]);
        end
    endtask

    // Deletes mostly target a value that is in the list, at a random position.
    task automatic send_random(int add_pct, int delete_pct);
        int                roll;
        int                pos;
        logic [LINK_W-1:0] walk;
        kind_t             kind;
        logic [DATA_W-1:0] value;
        roll = $urandom_range(0, 99);
        value = pick_value();
        if (roll < add_pct) begin
            if ($urandom_range(0, 1) == 0) begin
                kind = KIND_ADD_HEAD;
            end else begin
                kind = KIND_ADD_TAIL;
            end
        end else if (roll < add_pct + delete_pct) begin
            kind = KIND_DELETE;
            if (list_len > 0 && $urandom_range(0, 99) < 80) begin
                pos = $urandom_range(0, list_len - 1);
                walk = head_slot;
                repeat (pos) walk = node_next[walk];
                value = node_value[walk];
            end
        end else begin
            kind = KIND_READ_OUT;
        end
        send_request(kind, value, 1'b0, STATUS_OK);
    endtask

    task automatic flag_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
        $display("MISMATCH %s at result %0d: got %h, expected %h", what, results_seen, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 60) begin
                m_axis_tready <= 1'b1;
                ready_hold <= $urandom_range(0, 20);
            end else if (ready_roll < 95) begin
                m_axis_tready <= 1'b0;
                ready_hold <= $urandom_range(0, 3);
            end else begin
                m_axis_tready <= 1'b0;
                ready_hold <= $urandom_range(10, 40);
            end
        end
    end

    always @(posedge aclk) begin
        list_result_t want;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (awaited_results.size() == 0) begin
                    flag_mismatch("unexpected result", m_axis_tdata, '0);
                end else begin
                    want = awaited_results.pop_front();
                    if (m_axis_tuser != want.status)
                        flag_mismatch("status", {30'd0, m_axis_tuser}, {30'd0, want.status});
                    if (m_axis_tdata != want.data)
                        flag_mismatch("data", m_axis_tdata, want.data);
                    if (m_axis_tlast != want.last)
                        flag_mismatch("last", {31'd0, m_axis_tlast}, {31'd0, want.last});
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no request moved for %0d cycles", idle_cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_ADD_HEAD;
        head_slot     = NULL_LINK;
        used_slots    = 0;
        list_len      = 0;
        for (i = 0; i < 4; i++) kind_count[i] = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < SCRIPT_LEN; i++) begin
            send_request(script_rows[i].kind, script_rows[i].value,
                         script_rows[i].pinned, script_rows[i].status);
        end

        // fill the store first, then churn on it once it is full
        for (i = SCRIPT_LEN; i < TOTAL_REQUESTS; i++) begin
            if (used_slots < CAPACITY) begin
                send_random(85, 5);
            end else begin
                send_random(15, 30);
            end
        end
        s_axis_tvalid <= 1'b0;

        wait (awaited_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Requests: %0d add-head, %0d add-tail, %0d delete, %0d read-out; %0d hit full",
                 kind_count[KIND_ADD_HEAD], kind_count[KIND_ADD_TAIL],
                 kind_count[KIND_DELETE], kind_count[KIND_READ_OUT], full_rejects);
        $display("Results checked: %0d, longest read-out %0d nodes, mismatches %0d",
                 results_seen, longest_walk, error_count);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
src/alle_pkg.sv
src/alle_store.sv
src/alle_ctrl.sv
src/array_linked_list_engine.sv
test/array_linked_list_engine_tb.sv
